// File: design/rcic_pkg.sv
package rcic_pkg;

    // inode positions per inode-table block (power of two: shift and mask)
    localparam int INODES_PER_BLOCK = 8;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_MISS      = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_RELEASED  = 3'd3;
    localparam logic [2:0] ST_WRITEBACK = 3'd4;
    localparam logic [2:0] ST_UNUSED    = 3'd5;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  device;
        logic [23:0] inode_number;
        logic [5:0]  slot_in;
        logic        modified;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot_out;
        logic [21:0] block_number;
        logic [2:0]  inode_offset;
        logic [3:0]  device_out;
    } t_res;

    // one cache slot as held in the slot memory
    typedef struct packed {
        logic [3:0]  device;
        logic [23:0] inode;
        logic [7:0]  refs;
        logic        dirty;
    } t_entry;

endpackage

// File: design/refcounted_inode_cache.sv
// channel   | direction | handshake                    | payload
// ----------+-----------+------------------------------+---------------------------
// request   | in        | start high while busy low    | i_req (rcic_pkg::t_req)
// result    | out       | o_res_stb high for one cycle | o_res (rcic_pkg::t_res)
// config    | in        | i_cfg_wr_en high             | i_cfg_wr_data (table start)
//
// acquire: one pass through the slot memory (one read a cycle, registered read
//   data) then a write, with the result strobe
// release: a single read-modify-write of the slot (no slot access if out of range,
//   the strobe then follows the accepting edge directly)
// busy stays high until the result is presented; the receiver cannot stall
// synchronous active-low reset clears the slot valid bits (slots read as zero
//   until first written) and the inode table start; no clearing pass is needed
module refcounted_inode_cache #(
    parameter int CACHE_SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  rcic_pkg::t_req    i_req,
    output logic              busy,
    output logic              o_res_stb,
    output rcic_pkg::t_res    o_res,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data
);

    localparam int IW = $clog2(CACHE_SLOTS);
    localparam int CW = $clog2(CACHE_SLOTS + 1);
    localparam int EW = $bits(rcic_pkg::t_entry);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_ACT  = 4'b0100,
        S_REL  = 4'b1000
    } t_state;

    // build a result; block and offset only for a fetch or write-back
    function automatic rcic_pkg::t_res make_res(
        input logic [2:0]  status,
        input logic [5:0]  slot,
        input logic [3:0]  dev,
        input logic [23:0] ino,
        input logic [15:0] tbl_start
    );
        rcic_pkg::t_res res;
        logic [23:0]    idx;
        res          = '0;
        idx          = ino - 24'd1;
        res.status   = status;
        res.slot_out = slot;
        if (status == rcic_pkg::ST_MISS || status == rcic_pkg::ST_WRITEBACK) begin
            res.block_number = 22'(idx / rcic_pkg::INODES_PER_BLOCK) + 22'(tbl_start);
            res.inode_offset = 3'(idx % rcic_pkg::INODES_PER_BLOCK);
            res.device_out   = dev;
        end
        return res;
    endfunction

    // registers
    t_state                r_state, n_state;
    rcic_pkg::t_req        r_req, n_req;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_hit, n_hit;
    logic [IW-1:0]         r_hit_idx, n_hit_idx;
    rcic_pkg::t_entry      r_hit_e, n_hit_e;
    logic                  r_free, n_free;
    logic [IW-1:0]         r_free_idx, n_free_idx;
    logic [CACHE_SLOTS-1:0] r_valid, n_valid;
    logic                  r_vq;
    logic [15:0]           r_start, n_start;
    rcic_pkg::t_res        r_res, n_res;
    logic                  r_res_stb, n_res_stb;

    // memory port signals
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic [EW-1:0]         rd_q;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    rcic_pkg::t_entry      wr_e;

    // scan helpers
    rcic_pkg::t_entry      cur_e;
    logic [CW-1:0]         cnt_m1;
    logic [IW-1:0]         chk_idx;
    logic                  match;
    rcic_pkg::t_entry      rel_e;
    logic                  rel_dirty;
    logic [7:0]            rel_refs;

    rcic_ram #(
        .WIDTH (EW),
        .DEPTH (CACHE_SLOTS)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_e),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_q)
    );

    // a slot never written reads as all zero
    assign cur_e   = r_vq ? rcic_pkg::t_entry'(rd_q) : '0;
    assign cnt_m1  = r_cnt - CW'(1);
    assign chk_idx = cnt_m1[IW-1:0];
    assign match   = (cur_e.inode != 24'd0) && (cur_e.inode == r_req.inode_number)
                     && (cur_e.device == r_req.device);

    // release update: mark dirty first, then count down
    assign rel_dirty = cur_e.dirty | r_req.modified;
    assign rel_refs  = cur_e.refs - 8'd1;

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_cnt      = r_cnt;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_e    = r_hit_e;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_valid    = r_valid;
        n_start    = r_start;
        n_res      = r_res;
        n_res_stb  = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_cnt[IW-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_hit_idx;
        wr_e       = r_hit_e;
        rel_e      = cur_e;

        if (i_cfg_wr_en) begin
            n_start = i_cfg_wr_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    if (i_req.cmd == rcic_pkg::CMD_ACQUIRE) begin
                        n_cnt   = '0;
                        n_hit   = 1'b0;
                        n_free  = 1'b0;
                        n_state = S_SCAN;
                    end else if (32'(i_req.slot_in) >= CACHE_SLOTS) begin
                        // slot beyond the table: answered at once
                        n_res     = make_res(rcic_pkg::ST_UNUSED, i_req.slot_in,
                                             4'd0, 24'd0, r_start);
                        n_res_stb = 1'b1;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = IW'(i_req.slot_in);
                        n_state = S_REL;
                    end
                end
            end

            S_SCAN: begin
                // issue one read a cycle, check the one issued the cycle before
                if (r_cnt < CW'(CACHE_SLOTS)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_cnt[IW-1:0];
                end
                if (r_cnt != '0) begin
                    if (match && !r_hit) begin
                        n_hit     = 1'b1;
                        n_hit_idx = chk_idx;
                        n_hit_e   = cur_e;
                    end
                    if (cur_e.refs == 8'd0 && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = chk_idx;
                    end
                end
                if (r_cnt == CW'(CACHE_SLOTS)) begin
                    n_state = S_ACT;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end

            S_ACT: begin
                n_state   = S_IDLE;
                n_res_stb = 1'b1;
                priority if (r_hit) begin
                    wr_en   = 1'b1;
                    wr_addr = r_hit_idx;
                    wr_e    = r_hit_e;
                    // count saturates at its top
                    if (r_hit_e.refs != 8'hFF) begin
                        wr_e.refs = r_hit_e.refs + 8'd1;
                    end
                    n_res = make_res(rcic_pkg::ST_HIT, 6'(r_hit_idx), 4'd0, 24'd0, r_start);
                end else if (r_free) begin
                    wr_en        = 1'b1;
                    wr_addr      = r_free_idx;
                    wr_e.device  = r_req.device;
                    wr_e.inode   = r_req.inode_number;
                    wr_e.refs    = 8'd1;
                    wr_e.dirty   = 1'b0;
                    n_res = make_res(rcic_pkg::ST_MISS, 6'(r_free_idx), r_req.device,
                                     r_req.inode_number, r_start);
                end else begin
                    n_res = make_res(rcic_pkg::ST_FULL, 6'd0, 4'd0, 24'd0, r_start);
                end
            end

            S_REL: begin
                n_state   = S_IDLE;
                n_res_stb = 1'b1;
                wr_addr   = IW'(r_req.slot_in);
                if (cur_e.refs == 8'd0) begin
                    n_res = make_res(rcic_pkg::ST_UNUSED, r_req.slot_in, 4'd0, 24'd0,
                                     r_start);
                end else begin
                    wr_en      = 1'b1;
                    rel_e.refs = rel_refs;
                    if (rel_refs == 8'd0 && rel_dirty) begin
                        rel_e.dirty = 1'b0;
                        n_res = make_res(rcic_pkg::ST_WRITEBACK, r_req.slot_in,
                                         cur_e.device, cur_e.inode, r_start);
                    end else begin
                        rel_e.dirty = rel_dirty;
                        n_res = make_res(rcic_pkg::ST_RELEASED, r_req.slot_in, 4'd0,
                                         24'd0, r_start);
                    end
                    wr_e = rel_e;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (wr_en) begin
            n_valid[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_start   <= '0;
            r_res_stb <= 1'b0;
            r_cnt     <= '0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_start   <= n_start;
            r_res_stb <= n_res_stb;
            r_cnt     <= n_cnt;
            r_hit     <= n_hit;
            r_free    <= n_free;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_hit_idx  <= n_hit_idx;
        r_hit_e    <= n_hit_e;
        r_free_idx <= n_free_idx;
        r_res      <= n_res;
        if (rd_en) begin
            r_vq <= r_valid[rd_addr];
        end
    end

    assign busy      = (r_state != S_IDLE);
    assign o_res_stb = r_res_stb;
    assign o_res     = r_res;

endmodule

// File: design/rcic_ram.sv
module rcic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
